FILE: src/nearest_palette_color_search_defines.svh
// Assertion macros used by the checker file of the palette search block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

// same-cycle implication
`define NPCS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("npcs assertion failed (same cycle)");

// next-cycle implication
`define NPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("npcs assertion failed (next cycle)");

`endif

FILE: src/npcs_pkg.sv
// Package of the nearest palette color search block: sizes, opcodes, entry type.
// No dependencies; used by the interfaces, the top level and the checker.
package npcs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int PAL_CW          = $clog2(PALETTE_ENTRIES + 1);
  localparam int COLOR_W         = 8;
  localparam int IDX_W           = 8;
  localparam int SQ_W            = 2 * COLOR_W;
  localparam int DIST_W          = 18;
  localparam int MAX_DIST        = 195075;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pal_entry_t;

endpackage

FILE: src/npcs_if.sv
// Valid/ready channel interfaces of the palette search block: items in, results out.
// Depends on npcs_pkg for field widths.
interface npcs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [npcs_pkg::IDX_W-1:0]    entry_index;
  logic [npcs_pkg::COLOR_W-1:0]  red;
  logic [npcs_pkg::COLOR_W-1:0]  green;
  logic [npcs_pkg::COLOR_W-1:0]  blue;

  modport source (output valid, opcode, entry_index, red, green, blue, input ready);
  modport sink   (input valid, opcode, entry_index, red, green, blue, output ready);
endinterface

interface npcs_out_if;
  logic                          valid;
  logic                          ready;
  logic [npcs_pkg::IDX_W-1:0]    best_index;
  logic [npcs_pkg::DIST_W-1:0]   best_distance;

  modport source (output valid, best_index, best_distance, input ready);
  modport sink   (input valid, best_index, best_distance, output ready);
endinterface

FILE: src/nearest_palette_color_search.sv
// Top level of the nearest palette color search: palette RAM, scan pipeline, result register.
// Depends on npcs_pkg and the channel interfaces in npcs_if.sv.
//
//   channel | direction | transfer carries
//   in_i    | sink      | opcode, entry_index, red, green, blue
//   out_o   | source    | best_index, best_distance
//
// A load writes its entry and the block stays idle. A query reads one palette entry per
// cycle from the single RAM read port: PALETTE_ENTRIES reads pass through two pipeline
// stages, s1 and s2, and ST_FINISH then loads the result register. The result register frees
// the input side: a new item is taken while a result waits; a finished scan holds only if it
// is still full. Reset clears the valid bits at once; unwritten entries read as zero.
module nearest_palette_color_search (
  input  logic       clk_i,
  input  logic       rst_ni,
  npcs_in_if.sink    in_i,
  npcs_out_if.source out_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_e;

  state_e                              state_q;
  logic [npcs_pkg::PAL_CW-1:0]         rd_cnt_q;
  logic [npcs_pkg::COLOR_W-1:0]        qr_q, qg_q, qb_q;
  npcs_pkg::pal_entry_t                mem [npcs_pkg::PALETTE_ENTRIES];
  logic [npcs_pkg::PALETTE_ENTRIES-1:0] vld_bits_q;
  npcs_pkg::pal_entry_t                rdata_q;
  logic                                rvld_q;
  logic                                s1_vld_q, s1_last_q;
  logic [npcs_pkg::PAL_AW-1:0]         s1_idx_q;
  logic                                s2_vld_q, s2_last_q;
  logic [npcs_pkg::PAL_AW-1:0]         s2_idx_q;
  logic [npcs_pkg::SQ_W-1:0]           sq_r_q, sq_g_q, sq_b_q;
  logic                                have_q;
  logic [npcs_pkg::PAL_AW-1:0]         best_idx_q;
  logic [npcs_pkg::DIST_W-1:0]         best_dist_q;
  logic                                out_valid_q;
  logic [npcs_pkg::IDX_W-1:0]          out_idx_q;
  logic [npcs_pkg::DIST_W-1:0]         out_dist_q;

  logic                                in_xfer;
  logic                                wr_en;
  logic [npcs_pkg::PAL_AW-1:0]         wr_addr;
  npcs_pkg::pal_entry_t                wr_data;
  logic                                rd_en;
  logic [npcs_pkg::PAL_AW-1:0]         rd_addr;
  logic                                rd_last;
  npcs_pkg::pal_entry_t                entry;
  logic [npcs_pkg::COLOR_W-1:0]        dr, dg, db;
  logic [npcs_pkg::SQ_W-1:0]           sq_r, sq_g, sq_b;
  logic [npcs_pkg::DIST_W-1:0]         dist_sum;
  logic                                take;
  logic                                out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  assign wr_en   = in_xfer && (in_i.opcode == npcs_pkg::OP_LOAD) &&
                   (32'(in_i.entry_index) < npcs_pkg::PALETTE_ENTRIES);
  assign wr_addr = npcs_pkg::PAL_AW'(in_i.entry_index);
  assign wr_data = '{red: in_i.red, green: in_i.green, blue: in_i.blue};

  assign rd_en   = (state_q == ST_SCAN) &&
                   (rd_cnt_q < npcs_pkg::PAL_CW'(npcs_pkg::PALETTE_ENTRIES));
  assign rd_addr = rd_cnt_q[npcs_pkg::PAL_AW-1:0];
  assign rd_last = (rd_cnt_q == npcs_pkg::PAL_CW'(npcs_pkg::PALETTE_ENTRIES - 1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_bits_q <= '0;
      rvld_q     <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_bits_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_bits_q[rd_addr];
      end
    end
  end

  always_comb begin
    entry = rvld_q ? rdata_q : '0;
    dr    = (qr_q >= entry.red)   ? (qr_q - entry.red)   : (entry.red - qr_q);
    dg    = (qg_q >= entry.green) ? (qg_q - entry.green) : (entry.green - qg_q);
    db    = (qb_q >= entry.blue)  ? (qb_q - entry.blue)  : (entry.blue - qb_q);
    sq_r  = npcs_pkg::SQ_W'(dr) * npcs_pkg::SQ_W'(dr);
    sq_g  = npcs_pkg::SQ_W'(dg) * npcs_pkg::SQ_W'(dg);
    sq_b  = npcs_pkg::SQ_W'(db) * npcs_pkg::SQ_W'(db);
  end

  assign dist_sum = npcs_pkg::DIST_W'(sq_r_q) + npcs_pkg::DIST_W'(sq_g_q) +
                    npcs_pkg::DIST_W'(sq_b_q);
  assign take     = s2_vld_q && (!have_q || (dist_sum < best_dist_q));
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    sq_r_q <= sq_r;
    sq_g_q <= sq_g;
    sq_b_q <= sq_b;
    s1_idx_q <= rd_addr;
    s2_idx_q <= s1_idx_q;
    if (in_xfer) begin
      qr_q <= in_i.red;
      qg_q <= in_i.green;
      qb_q <= in_i.blue;
    end
    if (take) begin
      best_idx_q  <= s2_idx_q;
      best_dist_q <= dist_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      s1_vld_q    <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_vld_q    <= 1'b0;
      s2_last_q   <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_dist_q  <= '0;
    end else begin
      s1_vld_q  <= rd_en;
      s1_last_q <= rd_en && rd_last;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
      if (take) begin
        have_q <= 1'b1;
      end
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (in_i.opcode == npcs_pkg::OP_QUERY)) begin
            rd_cnt_q <= '0;
            have_q   <= 1'b0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_cnt_q <= rd_cnt_q + npcs_pkg::PAL_CW'(1);
          end
          if (s2_vld_q && s2_last_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= npcs_pkg::IDX_W'(best_idx_q);
            out_dist_q  <= best_dist_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.best_index    = out_idx_q;
  assign out_o.best_distance = out_dist_q;

endmodule

FILE: src/npcs_checker.sv
// Port-level checker of the palette search block and its bind to the top level.
// Depends on npcs_pkg and nearest_palette_color_search_defines.svh.
`include "nearest_palette_color_search_defines.svh"

module npcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_opcode_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [npcs_pkg::IDX_W-1:0]    out_best_index_i,
  input logic [npcs_pkg::DIST_W-1:0]   out_best_distance_i
);

  `NPCS_ASSERT_NEXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i)
  `NPCS_ASSERT_NEXT(a_out_data_hold, out_valid_i && !out_ready_i, $stable(out_best_index_i) && $stable(out_best_distance_i))
  `NPCS_ASSERT_NEXT(a_query_busy, in_valid_i && in_ready_i && (in_opcode_i == npcs_pkg::OP_QUERY), !in_ready_i)
  `NPCS_ASSERT_NEXT(a_load_ready, in_valid_i && in_ready_i && (in_opcode_i == npcs_pkg::OP_LOAD), in_ready_i)
  `NPCS_ASSERT_SAME(a_dist_range, out_valid_i, 32'(out_best_distance_i) <= npcs_pkg::MAX_DIST)

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .in_opcode_i         (in_i.opcode),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_best_index_i    (out_o.best_index),
  .out_best_distance_i (out_o.best_distance)
);

FILE: tb/nearest_palette_color_search_tb.sv
`timescale 1ns / 100ps
// Testbench of nearest_palette_color_search: a directed table, then random loads and queries.
// Depends on npcs_pkg, the channel interfaces in npcs_if.sv and the block itself.
module nearest_palette_color_search_tb;
  import npcs_pkg::*;

  localparam int RANDOM_ITEMS = 1930;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 2 * PALETTE_ENTRIES + 16;

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  entry_index;
    pal_entry_t        color;
    logic              typed;
    logic [IDX_W-1:0]  exp_index;
    logic [DIST_W-1:0] exp_distance;
  } stim_row_t;

  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
  } match_t;

  localparam int DIRECTED_ROWS = 20;

  const stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_QUERY, 8'd0,   24'h000000, 1'b1, 8'd0,   18'd0},
    '{OP_QUERY, 8'd0,   24'hffffff, 1'b1, 8'd0,   18'd195075},
    '{OP_QUERY, 8'd0,   24'hff0000, 1'b1, 8'd0,   18'd65025},
    '{OP_LOAD,  8'd255, 24'hffffff, 1'b0, 8'd0,   18'd0},
    '{OP_QUERY, 8'd0,   24'hffffff, 1'b1, 8'd255, 18'd0},
    '{OP_QUERY, 8'd255, 24'h000000, 1'b1, 8'd0,   18'd0},
    '{OP_LOAD,  8'd0,   24'hffffff, 1'b0, 8'd0,   18'd0},
    '{OP_QUERY, 8'd0,   24'hffffff, 1'b1, 8'd0,   18'd0},
    '{OP_QUERY, 8'd0,   24'h000000, 1'b1, 8'd1,   18'd0},
    '{OP_QUERY, 8'd0,   24'h0000ff, 1'b1, 8'd1,   18'd65025},
    '{OP_LOAD,  8'd128, 24'h0000ff, 1'b0, 8'd0,   18'd0},
    '{OP_QUERY, 8'd0,   24'h0000ff, 1'b1, 8'd128, 18'd0},
    '{OP_LOAD,  8'd1,   24'haa55aa, 1'b0, 8'd0,   18'd0},
    '{OP_LOAD,  8'd2,   24'h55aa55, 1'b0, 8'd0,   18'd0},
    '{OP_QUERY, 8'd170, 24'h55aa55, 1'b0, 8'd0,   18'd0},
    '{OP_QUERY, 8'd85,  24'ha956ab, 1'b0, 8'd0,   18'd0},
    '{OP_LOAD,  8'd3,   24'h010203, 1'b0, 8'd0,   18'd0},
    '{OP_QUERY, 8'd0,   24'h000000, 1'b0, 8'd0,   18'd0},
    '{OP_QUERY, 8'd0,   24'h808080, 1'b0, 8'd0,   18'd0},
    '{OP_QUERY, 8'd0,   24'h7f7f7f, 1'b0, 8'd0,   18'd0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  npcs_in_if  in_ch ();
  npcs_out_if out_ch ();

  nearest_palette_color_search i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  pal_entry_t palette_shadow [PALETTE_ENTRIES];
  match_t     pending_matches [$];
  int         mismatches     = 0;
  int         stall_cycles   = 0;
  int         feed_idle_pct  = 34;
  int         drain_idle_pct = 73;

  always #2 clk_i = ~clk_i;

  function automatic match_t nearest_color(pal_entry_t c);
    match_t best;
    int     dr, dg, db, sq_dist, lowest;
    best   = '0;
    lowest = MAX_DIST + 1;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      dr      = int'(c.red)   - int'(palette_shadow[i].red);
      dg      = int'(c.green) - int'(palette_shadow[i].green);
      db      = int'(c.blue)  - int'(palette_shadow[i].blue);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist < lowest) begin
        lowest          = sq_dist;
        best.best_index = IDX_W'(i);
      end
    end
    best.best_distance = DIST_W'(lowest);
    return best;
  endfunction

  function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COLOR_W'(v);
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t  row;
    pal_entry_t base;
    pal_entry_t corner;
    logic [2:0] mask;
    int         pick;
    row    = '0;
    mask   = 3'($urandom_range(7));
    corner = {{8{mask[2]}}, {8{mask[1]}}, {8{mask[0]}}};
    base   = palette_shadow[$urandom_range(PALETTE_ENTRIES - 1)];
    pick   = $urandom_range(99);
    row.entry_index = IDX_W'($urandom_range(255));
    if ($urandom_range(99) < 55) begin
      row.opcode = OP_LOAD;
      if (pick < 15) row.color = base;
      else if (pick < 25) row.color = corner;
      else row.color = pal_entry_t'(24'($urandom));
    end else begin
      row.opcode = OP_QUERY;
      if (pick < 30) row.color = base;
      else if (pick < 60) row.color = {nudge(base.red), nudge(base.green), nudge(base.blue)};
      else if (pick < 85) row.color = pal_entry_t'(24'($urandom));
      else row.color = corner;
    end
    return row;
  endfunction

  task automatic send_item(input stim_row_t row);
    while ($urandom_range(99) < feed_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= row.opcode;
    in_ch.entry_index <= row.entry_index;
    in_ch.red         <= row.color.red;
    in_ch.green       <= row.color.green;
    in_ch.blue        <= row.color.blue;
    do @(posedge clk_i); while (!in_ch.ready);
    if (row.opcode == OP_LOAD) begin
      palette_shadow[row.entry_index] = row.color;
    end else if (row.typed) begin
      pending_matches.push_back(match_t'{row.exp_index, row.exp_distance});
    end else begin
      pending_matches.push_back(nearest_color(row.color));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= drain_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    match_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: result with no query waiting: index %0d distance %0d",
                 $time, out_ch.best_index, out_ch.best_distance);
        mismatches++;
      end else begin
        want = pending_matches.pop_front();
        if (out_ch.best_index !== want.best_index) begin
          $display("%0t: best_index expected %0d actual %0d",
                   $time, want.best_index, out_ch.best_index);
          mismatches++;
        end
        if (out_ch.best_distance !== want.best_distance) begin
          $display("%0t: best_distance expected %0d actual %0d",
                   $time, want.best_distance, out_ch.best_distance);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("nearest_palette_color_search verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_QUERY;
    in_ch.entry_index = '0;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;
    foreach (palette_shadow[i]) palette_shadow[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        feed_idle_pct  = 73;
        drain_idle_pct = 34;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        feed_idle_pct  = 0;
        drain_idle_pct = 0;
      end
      send_item(random_row());
    end
    in_ch.valid <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("nearest_palette_color_search verification clean");
    end else begin
      $display("nearest_palette_color_search verification failed");
    end
    $finish;
  end

endmodule
